>>> rtl/integral_image_box_sum_top_macros.svh
// Assertion macros shared by the summed-area table RTL.
`ifndef INTEGRAL_IMAGE_BOX_SUM_TOP_MACROS_SVH
`define INTEGRAL_IMAGE_BOX_SUM_TOP_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define IIBS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define IIBS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define IIBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/iibs_pkg.sv
// Shared types and constants for the summed-area table block.
`timescale 1ns / 1ps

package iibs_pkg;

  localparam int PIX_W   = 16;  // pixel
  localparam int POS_W   = 12;  // query row / col
  localparam int SIZE_W  = 12;  // rectangle width / height
  localparam int HAAR_W  = 11;  // wavelet window side
  localparam int CFG_W   = 11;  // size registers
  localparam int IDX_W   = 2;   // config register index
  localparam int RES_W   = 37;  // result word
  localparam int CRD_W   = 14;  // signed coordinate arithmetic
  localparam int NCORNER = 8;   // corner slots per job
  localparam int PAIR_W  = 2;   // index of a corner pair

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

  typedef logic signed [CRD_W-1:0] crd_t;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_RECT   = 2'd1,
    REQ_HAAR_X = 2'd2,
    REQ_HAAR_Y = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    JOB_LOAD,
    JOB_RECT,
    JOB_HAAR
  } job_kind_t;

  // Control part of a queued job; corner addresses travel alongside.
  typedef struct packed {
    job_kind_t            kind;
    logic [PAIR_W-1:0]    last_pair;
    logic [NCORNER-1:0]   corner_ok;
  } job_ctrl_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_ACC
  } back_state_t;

endpackage

>>> rtl/iibs_cfg_if.sv
// Configuration write channel.
`timescale 1ns / 1ps

interface iibs_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [iibs_pkg::IDX_W-1:0]  index;
  logic [iibs_pkg::CFG_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/iibs_req_if.sv
// Request channel: pixel loads and box / wavelet queries.
`timescale 1ns / 1ps

interface iibs_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          req_type;
  logic [iibs_pkg::PIX_W-1:0]          pixel;
  logic signed [iibs_pkg::POS_W-1:0]   row;
  logic signed [iibs_pkg::POS_W-1:0]   col;
  logic [iibs_pkg::SIZE_W-1:0]         rect_width;
  logic [iibs_pkg::SIZE_W-1:0]         rect_height;
  logic [iibs_pkg::HAAR_W-1:0]         haar_size;

  modport source (output valid, req_type, pixel, row, col, rect_width, rect_height,
                  haar_size, input ready);
  modport sink (input valid, req_type, pixel, row, col, rect_width, rect_height,
                haar_size, output ready);
endinterface

>>> rtl/iibs_res_if.sv
// Result channel.
`timescale 1ns / 1ps

interface iibs_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [iibs_pkg::RES_W-1:0]  result_value;

  modport source (output valid, result_value, input ready);
  modport sink (input valid, result_value, output ready);
endinterface

>>> rtl/iibs_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps

module iibs_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/iibs_queue.sv
// Small FIFO between the front and back halves.
`timescale 1ns / 1ps
`include "integral_image_box_sum_top_macros.svh"

module iibs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             valid
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign valid    = (count != '0);
  assign full     = (count == CNT_W'(DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `IIBS_ASSERT_IMPLY(a_no_push_full, push, !full, "queue push while full")
  `IIBS_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH), "queue count overflow")
  `IIBS_ASSERT_NEXT(a_fill, push && !pop, count == $past(count) + 1'b1, "queue fill lost")

endmodule

>>> rtl/iibs_front.sv
// Front half: config registers, load bookkeeping and corner address generation.
`timescale 1ns / 1ps

module iibs_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT),
  localparam int ADDR_W = COL_W + ROW_W,
  localparam int RS_W = iibs_pkg::PIX_W + COL_W
) (
  input  logic                                        clk,
  input  logic                                        rst,
  iibs_cfg_if.sink                                    cfg,
  iibs_req_if.sink                                    req,
  output logic                                        job_push,
  input  logic                                        job_full,
  output iibs_pkg::job_ctrl_t                         job_ctrl,
  output logic [iibs_pkg::NCORNER-1:0][ADDR_W-1:0]    job_addr,
  output logic [RS_W-1:0]                             job_rsum
);

  localparam int CRD_W = iibs_pkg::CRD_W;

  typedef struct packed {
    iibs_pkg::crd_t top;
    iibs_pkg::crd_t left;
    iibs_pkg::crd_t bottom;
    iibs_pkg::crd_t right;
  } box_t;

  function automatic logic [CRD_W-1:0] eff_size(logic [iibs_pkg::CFG_W-1:0] v, int lim);
    if (v == '0) begin
      return CRD_W'(1);
    end
    if (int'(v) > lim) begin
      return CRD_W'(lim);
    end
    return CRD_W'(v);
  endfunction

  // Corner coordinates of a box: top/left step back one, far side clamps to the image.
  function automatic box_t clip_box(box_t b, iibs_pkg::crd_t eh, iibs_pkg::crd_t ew);
    box_t o;
    o.top    = (b.top <= eh) ? b.top - iibs_pkg::crd_t'(1) : iibs_pkg::crd_t'(-1);
    o.left   = (b.left <= ew) ? b.left - iibs_pkg::crd_t'(1) : iibs_pkg::crd_t'(-1);
    o.bottom = (b.bottom < eh) ? b.bottom : eh - iibs_pkg::crd_t'(1);
    o.right  = (b.right < ew) ? b.right : ew - iibs_pkg::crd_t'(1);
    return o;
  endfunction

  function automatic logic in_range(iibs_pkg::crd_t x, iibs_pkg::crd_t lim);
    return (x >= 0) && (x < lim);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(iibs_pkg::crd_t r, iibs_pkg::crd_t c);
    return {r[ROW_W-1:0], c[COL_W-1:0]};
  endfunction

  // config and load position
  logic [iibs_pkg::CFG_W-1:0] image_width;
  logic [iibs_pkg::CFG_W-1:0] image_height;
  logic [COL_W-1:0]           col_pos;
  logic [ROW_W-1:0]           row_pos;
  logic [RS_W-1:0]            rsum;
  logic [RS_W-1:0]            rsum_next;
  logic [COL_W:0]             col_inc;
  logic [ROW_W:0]             row_inc;
  logic [CRD_W-1:0]           eff_w;
  logic [CRD_W-1:0]           eff_h;
  iibs_pkg::crd_t             ew_s;
  iibs_pkg::crd_t             eh_s;

  // staged word
  logic                       s_valid;
  iibs_pkg::req_type_t        s_type;
  logic [iibs_pkg::PIX_W-1:0] s_pixel;
  box_t                       s_box [2];
  box_t                       in_box [2];

  iibs_pkg::crd_t             r_in;
  iibs_pkg::crd_t             c_in;
  iibs_pkg::crd_t             rw_in;
  iibs_pkg::crd_t             rh_in;
  iibs_pkg::crd_t             sz_in;
  iibs_pkg::crd_t             half_in;
  iibs_pkg::crd_t             one;
  box_t                       clip [2];
  logic                       is_load;

  assign cfg.ready = 1'b1;
  assign eff_w = eff_size(image_width, MAX_WIDTH);
  assign eff_h = eff_size(image_height, MAX_HEIGHT);
  assign ew_s  = $signed(eff_w);
  assign eh_s  = $signed(eff_h);
  assign one   = iibs_pkg::crd_t'(1);

  assign job_push  = s_valid && !job_full;
  assign req.ready = !s_valid || job_push;
  assign is_load   = (s_type == iibs_pkg::REQ_LOAD);

  // box parameters straight from the request
  always_comb begin
    r_in    = {{(CRD_W - iibs_pkg::POS_W){req.row[iibs_pkg::POS_W-1]}}, req.row};
    c_in    = {{(CRD_W - iibs_pkg::POS_W){req.col[iibs_pkg::POS_W-1]}}, req.col};
    rw_in   = {{(CRD_W - iibs_pkg::SIZE_W){1'b0}}, req.rect_width};
    rh_in   = {{(CRD_W - iibs_pkg::SIZE_W){1'b0}}, req.rect_height};
    sz_in   = {{(CRD_W - iibs_pkg::HAAR_W){1'b0}}, req.haar_size};
    half_in = {{(CRD_W - iibs_pkg::HAAR_W + 1){1'b0}}, req.haar_size[iibs_pkg::HAAR_W-1:1]};
    case (iibs_pkg::req_type_t'(req.req_type))
      iibs_pkg::REQ_HAAR_X: begin
        in_box[0].top    = r_in;
        in_box[0].left   = c_in + half_in;
        in_box[0].bottom = r_in + sz_in - one;
        in_box[0].right  = c_in + half_in + half_in - one;
        in_box[1].top    = r_in;
        in_box[1].left   = c_in;
        in_box[1].bottom = r_in + sz_in - one;
        in_box[1].right  = c_in + half_in - one;
      end
      iibs_pkg::REQ_HAAR_Y: begin
        in_box[0].top    = r_in + half_in;
        in_box[0].left   = c_in;
        in_box[0].bottom = r_in + half_in + half_in - one;
        in_box[0].right  = c_in + sz_in - one;
        in_box[1].top    = r_in;
        in_box[1].left   = c_in;
        in_box[1].bottom = r_in + half_in - one;
        in_box[1].right  = c_in + sz_in - one;
      end
      default: begin
        in_box[0].top    = r_in;
        in_box[0].left   = c_in;
        in_box[0].bottom = r_in + rh_in - one;
        in_box[0].right  = c_in + rw_in - one;
        in_box[1]        = in_box[0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (req.ready) begin
      s_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s_type   <= iibs_pkg::req_type_t'(req.req_type);
      s_pixel  <= req.pixel;
      s_box[0] <= in_box[0];
      s_box[1] <= in_box[1];
    end
  end

  // job word: corner order per box is TL, TR, BR, BL so each pair adds as first minus second
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      clip[k] = clip_box(s_box[k], eh_s, ew_s);
    end
    job_addr           = '0;
    job_ctrl.corner_ok = '0;
    rsum_next          = ((col_pos == '0) ? '0 : rsum) + RS_W'(s_pixel);
    job_rsum           = rsum_next;
    case (s_type)
      iibs_pkg::REQ_LOAD: begin
        job_ctrl.kind         = iibs_pkg::JOB_LOAD;
        job_ctrl.last_pair    = iibs_pkg::PAIR_W'(0);
        job_addr[0]           = {row_pos - 1'b1, col_pos};
        job_addr[1]           = {row_pos, col_pos};
        job_ctrl.corner_ok[0] = (row_pos != '0);
      end
      iibs_pkg::REQ_RECT: begin
        job_ctrl.kind      = iibs_pkg::JOB_RECT;
        job_ctrl.last_pair = iibs_pkg::PAIR_W'(1);
      end
      default: begin
        job_ctrl.kind      = iibs_pkg::JOB_HAAR;
        job_ctrl.last_pair = iibs_pkg::PAIR_W'(3);
      end
    endcase
    if (!is_load) begin
      for (int k = 0; k < 2; k++) begin
        job_addr[4*k]             = addr_of(clip[k].top, clip[k].left);
        job_addr[4*k+1]           = addr_of(clip[k].top, clip[k].right);
        job_addr[4*k+2]           = addr_of(clip[k].bottom, clip[k].right);
        job_addr[4*k+3]           = addr_of(clip[k].bottom, clip[k].left);
        job_ctrl.corner_ok[4*k]   = in_range(clip[k].top, eh_s) && in_range(clip[k].left, ew_s);
        job_ctrl.corner_ok[4*k+1] = in_range(clip[k].top, eh_s) && in_range(clip[k].right, ew_s);
        job_ctrl.corner_ok[4*k+2] = in_range(clip[k].bottom, eh_s)
                                    && in_range(clip[k].right, ew_s);
        job_ctrl.corner_ok[4*k+3] = in_range(clip[k].bottom, eh_s)
                                    && in_range(clip[k].left, ew_s);
      end
    end
  end

  assign col_inc = {1'b0, col_pos} + 1'b1;
  assign row_inc = {1'b0, row_pos} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= iibs_pkg::SIZE_RESET;
      image_height <= iibs_pkg::SIZE_RESET;
      col_pos      <= '0;
      row_pos      <= '0;
      rsum         <= '0;
    end else if (cfg.valid && (cfg.index == iibs_pkg::REG_IMAGE_WIDTH
                               || cfg.index == iibs_pkg::REG_IMAGE_HEIGHT)) begin
      if (cfg.index == iibs_pkg::REG_IMAGE_WIDTH) begin
        image_width <= cfg.data;
      end else begin
        image_height <= cfg.data;
      end
      col_pos <= '0;
      row_pos <= '0;
      rsum    <= '0;
    end else if (job_push && is_load) begin
      rsum <= rsum_next;
      if (CRD_W'(col_inc) >= eff_w) begin
        col_pos <= '0;
        row_pos <= (CRD_W'(row_inc) >= eff_h) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_pos <= col_inc[COL_W-1:0];
      end
    end
  end

endmodule

>>> rtl/iibs_back.sv
// Back half: reads table corners two per cycle, accumulates, writes loads, holds the result.
`timescale 1ns / 1ps
`include "integral_image_box_sum_top_macros.svh"

module iibs_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT),
  localparam int ADDR_W = COL_W + ROW_W,
  localparam int RS_W = iibs_pkg::PIX_W + COL_W
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      q_valid,
  output logic                                      q_pop,
  input  iibs_pkg::job_ctrl_t                       q_ctrl,
  input  logic [iibs_pkg::NCORNER-1:0][ADDR_W-1:0]  q_addr,
  input  logic [RS_W-1:0]                           q_rsum,
  iibs_res_if.source                                res
);

  localparam int ENTRY_W = iibs_pkg::PIX_W + COL_W + ROW_W;
  localparam int ACC_W = (ENTRY_W + 2 > iibs_pkg::RES_W) ? ENTRY_W + 2 : iibs_pkg::RES_W;
  localparam int DEPTH = MAX_HEIGHT * (2 ** COL_W);

  iibs_pkg::back_state_t                   state;
  iibs_pkg::back_state_t                   state_next;
  logic [iibs_pkg::PAIR_W-1:0]             step;
  logic [iibs_pkg::PAIR_W-1:0]             arr;
  iibs_pkg::job_ctrl_t                     j_ctrl;
  logic [iibs_pkg::NCORNER-1:0][ADDR_W-1:0] j_addr;
  logic [RS_W-1:0]                         j_rsum;
  logic signed [ACC_W-1:0]                 acc;
  logic signed [ACC_W-1:0]                 pos;
  logic                                    out_valid;
  logic signed [iibs_pkg::RES_W-1:0]       out_value;

  logic                                    out_free;
  logic                                    commit;
  logic                                    ram_we;
  logic [ENTRY_W-1:0]                      rdata_a;
  logic [ENTRY_W-1:0]                      rdata_b;
  logic signed [ACC_W-1:0]                 m_a;
  logic signed [ACC_W-1:0]                 m_b;
  logic signed [ACC_W-1:0]                 diff;
  logic signed [ACC_W-1:0]                 box_sum;
  logic signed [ACC_W-1:0]                 box_clamp;
  logic signed [ACC_W-1:0]                 load_val;
  logic signed [ACC_W-1:0]                 result;

  iibs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (j_addr[1]),
    .wdata   (load_val[ENTRY_W-1:0]),
    .raddr_a (j_addr[{step, 1'b0}]),
    .rdata_a (rdata_a),
    .raddr_b (j_addr[{step, 1'b1}]),
    .rdata_b (rdata_b)
  );

  assign out_free         = !out_valid || res.ready;
  assign res.valid        = out_valid;
  assign res.result_value = out_value;

  // pair whose read data is on the RAM outputs this cycle
  assign arr       = (state == iibs_pkg::B_ACC) ? step : step - 1'b1;
  assign m_a       = j_ctrl.corner_ok[{arr, 1'b0}] ? $signed(ACC_W'(rdata_a)) : '0;
  assign m_b       = j_ctrl.corner_ok[{arr, 1'b1}] ? $signed(ACC_W'(rdata_b)) : '0;
  assign diff      = m_a - m_b;
  assign box_sum   = acc + diff;
  assign box_clamp = (box_sum > 0) ? box_sum : '0;
  assign load_val  = m_a + $signed(ACC_W'(j_rsum));

  always_comb begin
    case (j_ctrl.kind)
      iibs_pkg::JOB_LOAD: result = load_val;
      iibs_pkg::JOB_RECT: result = box_clamp;
      iibs_pkg::JOB_HAAR: result = pos - box_clamp;
      default:            result = '0;
    endcase
  end

  always_comb begin
    case (state)
      iibs_pkg::B_IDLE: begin
        state_next = q_valid ? iibs_pkg::B_READ : iibs_pkg::B_IDLE;
      end
      iibs_pkg::B_READ: begin
        state_next = (step == j_ctrl.last_pair) ? iibs_pkg::B_ACC : iibs_pkg::B_READ;
      end
      iibs_pkg::B_ACC: begin
        if (!out_free) begin
          state_next = iibs_pkg::B_ACC;
        end else begin
          state_next = q_valid ? iibs_pkg::B_READ : iibs_pkg::B_IDLE;
        end
      end
      default: state_next = iibs_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      iibs_pkg::B_IDLE: begin
        commit = 1'b0;
        q_pop  = q_valid;
      end
      iibs_pkg::B_ACC: begin
        commit = out_free;
        q_pop  = out_free && q_valid;
      end
      default: begin
        commit = 1'b0;
        q_pop  = 1'b0;
      end
    endcase
    ram_we = commit && (j_ctrl.kind == iibs_pkg::JOB_LOAD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= iibs_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      j_ctrl <= q_ctrl;
      j_addr <= q_addr;
      j_rsum <= q_rsum;
      step   <= '0;
    end else if (state == iibs_pkg::B_READ && step != j_ctrl.last_pair) begin
      step <= step + 1'b1;
    end
    if (state == iibs_pkg::B_READ && step != '0) begin
      if (!arr[0]) begin
        acc <= diff;
      end else begin
        pos <= box_clamp;
      end
    end
    if (commit) begin
      out_value <= result[iibs_pkg::RES_W-1:0];
    end
  end

  `IIBS_ASSERT_IMPLY(a_step_bound, state == iibs_pkg::B_READ, step <= j_ctrl.last_pair, "step past last pair")
  `IIBS_ASSERT_IMPLY(a_acc_last, state == iibs_pkg::B_ACC, step == j_ctrl.last_pair, "finish before all pairs read")
  `IIBS_ASSERT_NEXT(a_pop_start, q_pop, state == iibs_pkg::B_READ && step == '0, "popped job not started")
  `IIBS_ASSERT_NEXT(a_commit_shown, commit, out_valid, "committed word not shown")

endmodule

>>> rtl/integral_image_box_sum_top.sv
// Throughput: the table reader handles two corners per cycle through the RAM's two read ports,
// so a load reads one corner pair, a rectangle sum two and a Haar response four (eight corners).
// A 4-deep job queue lets acceptance run ahead of the reader.
// Reset: size registers 1024, load position at row 0 column 0, running row sum 0; table
// contents are undefined until loaded and are not cleared.
`timescale 1ns / 1ps

module integral_image_box_sum_top #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  iibs_cfg_if.sink    cfg,
  iibs_req_if.sink    req,
  iibs_res_if.source  res
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int RS_W = iibs_pkg::PIX_W + COL_W;
  localparam int Q_W = $bits(iibs_pkg::job_ctrl_t) + iibs_pkg::NCORNER * ADDR_W + RS_W;
  localparam int QUEUE_DEPTH = 4;

  logic                                      f_push;
  logic                                      q_full;
  iibs_pkg::job_ctrl_t                       f_ctrl;
  logic [iibs_pkg::NCORNER-1:0][ADDR_W-1:0]  f_addr;
  logic [RS_W-1:0]                           f_rsum;
  logic [Q_W-1:0]                            push_data;
  logic [Q_W-1:0]                            pop_data;
  logic                                      q_valid;
  logic                                      q_pop;
  iibs_pkg::job_ctrl_t                       b_ctrl;
  logic [iibs_pkg::NCORNER-1:0][ADDR_W-1:0]  b_addr;
  logic [RS_W-1:0]                           b_rsum;

  assign push_data = {f_ctrl, f_addr, f_rsum};
  assign {b_ctrl, b_addr, b_rsum} = pop_data;

  iibs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .req      (req),
    .job_push (f_push),
    .job_full (q_full),
    .job_ctrl (f_ctrl),
    .job_addr (f_addr),
    .job_rsum (f_rsum)
  );

  iibs_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .valid     (q_valid)
  );

  iibs_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_ctrl  (b_ctrl),
    .q_addr  (b_addr),
    .q_rsum  (b_rsum),
    .res     (res)
  );

endmodule
